>>> rtl/core/b64q_pkg.sv
`timescale 1ns / 1ps
// Package: types, codes and constants shared by the base64 quartet decoder.
package b64q_pkg;

   localparam int unsigned LANES = 4;
   localparam int unsigned CHAR_W = 8;
   localparam int unsigned VALUE_W = 7;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

   localparam logic [VALUE_W-1:0] VALUE_LOWER_BASE = 7'd26;
   localparam logic [VALUE_W-1:0] VALUE_DIGIT_BASE = 7'd52;
   localparam logic [VALUE_W-1:0] VALUE_62 = 7'd62;
   localparam logic [VALUE_W-1:0] VALUE_63 = 7'd63;
   localparam logic [VALUE_W-1:0] VALUE_INVALID = 7'd64;

   localparam logic [CHAR_W-1:0] RESET_SYMBOL_62 = 8'd43;
   localparam logic [CHAR_W-1:0] RESET_SYMBOL_63 = 8'd47;
   localparam logic [CHAR_W-1:0] RESET_PAD_CHAR = 8'd61;

   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_62 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_63 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_CHAR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_INVALID = 3'd3;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE = 2'd1;
   localparam logic [1:0] COUNT_TWO = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_BAD_FIRST = 3'd1,
      STATUS_BAD_SECOND = 3'd2,
      STATUS_BAD_FOURTH = 3'd3,
      STATUS_BAD_THIRD = 3'd4
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_a;
      logic [CHAR_W-1:0] char_b;
      logic [CHAR_W-1:0] char_c;
      logic [CHAR_W-1:0] char_d;
      logic last_quartet;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [1:0] byte_count;
      status_type status;
      logic end_of_message;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic is_pad;
   } lane_type;

endpackage

>>> rtl/core/b64q_lane.sv
`timescale 1ns / 1ps
// One character lane: alphabet lookup and pad match.
module b64q_lane (
   input  logic [b64q_pkg::CHAR_W-1:0] char_in,
   input  logic [b64q_pkg::CHAR_W-1:0] symbol_62,
   input  logic [b64q_pkg::CHAR_W-1:0] symbol_63,
   input  logic [b64q_pkg::CHAR_W-1:0] pad_char,
   output b64q_pkg::lane_type          lane_out
);

   always_comb begin
      lane_out.is_pad = (char_in == pad_char);
      if (char_in == symbol_63) begin
         lane_out.value = b64q_pkg::VALUE_63;
      end else if (char_in == symbol_62) begin
         lane_out.value = b64q_pkg::VALUE_62;
      end else if (char_in >= b64q_pkg::CHAR_UPPER_A && char_in <= b64q_pkg::CHAR_UPPER_Z) begin
         lane_out.value = 7'(char_in - b64q_pkg::CHAR_UPPER_A);
      end else if (char_in >= b64q_pkg::CHAR_LOWER_A && char_in <= b64q_pkg::CHAR_LOWER_Z) begin
         lane_out.value = 7'(char_in - b64q_pkg::CHAR_LOWER_A) + b64q_pkg::VALUE_LOWER_BASE;
      end else if (char_in >= b64q_pkg::CHAR_DIGIT_0 && char_in <= b64q_pkg::CHAR_DIGIT_9) begin
         lane_out.value = 7'(char_in - b64q_pkg::CHAR_DIGIT_0) + b64q_pkg::VALUE_DIGIT_BASE;
      end else begin
         lane_out.value = b64q_pkg::VALUE_INVALID;
      end
   end

endmodule

>>> rtl/core/b64q_merge.sv
`timescale 1ns / 1ps
// Merge stage: combines the four lanes into bytes, count and status; holds the error latch.
module b64q_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 ignore_invalid,
   input  logic                 last_quartet,
   input  b64q_pkg::lane_type   lane_a,
   input  b64q_pkg::lane_type   lane_b,
   input  b64q_pkg::lane_type   lane_c,
   input  b64q_pkg::lane_type   lane_d,
   output b64q_pkg::rsp_type    result
);

   b64q_pkg::status_type latch_ff;
   b64q_pkg::status_type latch_in;
   b64q_pkg::status_type status;
   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] b2;

   assign b0 = {lane_a.value[5:0], 2'b00} | {5'b0, lane_b.value[6:4]};
   assign b1 = {lane_b.value[3:0], 4'b0000} | {3'b0, lane_c.value[6:2]};
   assign b2 = {lane_c.value[1:0], 6'b0} | {1'b0, lane_d.value};

   always_comb begin
      result = '0;
      result.end_of_message = last_quartet;
      status = b64q_pkg::STATUS_OK;
      latch_in = latch_ff;
      if (latch_ff != b64q_pkg::STATUS_OK) begin
         status = latch_ff;
         if (last_quartet) begin
            latch_in = b64q_pkg::STATUS_OK;
         end
      end else begin
         if (lane_a.value[6] && !ignore_invalid) begin
            status = b64q_pkg::STATUS_BAD_FIRST;
         end else if (lane_b.value[6] && !ignore_invalid) begin
            status = b64q_pkg::STATUS_BAD_SECOND;
         end else if (!lane_c.value[6]) begin
            if (!lane_d.value[6]) begin
               result.byte_first = b0;
               result.byte_second = b1;
               result.byte_third = b2;
               result.byte_count = b64q_pkg::COUNT_THREE;
            end else if (!lane_d.is_pad && !ignore_invalid) begin
               status = b64q_pkg::STATUS_BAD_FOURTH;
            end else begin
               result.byte_first = b0;
               result.byte_second = b1;
               result.byte_count = b64q_pkg::COUNT_TWO;
            end
         end else if (!lane_c.is_pad && !ignore_invalid) begin
            status = b64q_pkg::STATUS_BAD_THIRD;
         end else begin
            result.byte_first = b0;
            result.byte_count = b64q_pkg::COUNT_ONE;
         end
         if (status != b64q_pkg::STATUS_OK && !last_quartet) begin
            latch_in = status;
         end
      end
      result.status = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= b64q_pkg::STATUS_OK;
      end else if (accept) begin
         latch_ff <= latch_in;
      end
   end

   // latched error repeats with no bytes
   assert property (@(posedge clock) disable iff (reset)
      (latch_ff != b64q_pkg::STATUS_OK) |->
         (result.byte_count == b64q_pkg::COUNT_NONE && result.status == latch_ff))
      else $error("latched error not repeated");

   // last request of a message always leaves the latch clear
   assert property (@(posedge clock) disable iff (reset)
      (accept && last_quartet) |=> (latch_ff == b64q_pkg::STATUS_OK))
      else $error("error latch survived end of message");

   assert property (@(posedge clock) disable iff (reset)
      (result.status != b64q_pkg::STATUS_OK) |->
         (result.byte_first == 8'd0 && result.byte_second == 8'd0 &&
          result.byte_third == 8'd0 && result.byte_count == b64q_pkg::COUNT_NONE))
      else $error("bytes produced alongside an error");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(latch_ff))
      else $error("error latch moved without a request");

endmodule

>>> rtl/core/base64_quartet_decoder_core.sv
`timescale 1ns / 1ps
// Top level: base64 quartet decoder with four lookup lanes, merge stage and output skid.
// An accepted request is registered in the output register, or in the skid while it stalls.
// Throughput: one request per cycle unless req_stall; the four lanes and merge are combinational.
// A two-entry output stage (register plus skid) keeps req_stall low while one result waits.
// Reset (synchronous): registers return to '+', '/', '=', ignore off; error latch and valids clear.
module base64_quartet_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  b64q_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output b64q_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [b64q_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [b64q_pkg::CHAR_W-1:0]         csr_wdata
);

   logic [b64q_pkg::CHAR_W-1:0] symbol_62_ff;
   logic [b64q_pkg::CHAR_W-1:0] symbol_63_ff;
   logic [b64q_pkg::CHAR_W-1:0] pad_char_ff;
   logic                        ignore_ff;

   logic [b64q_pkg::CHAR_W-1:0] lane_char [b64q_pkg::LANES];
   b64q_pkg::lane_type          lane_res [b64q_pkg::LANES];
   b64q_pkg::rsp_type           merged;

   logic              out_valid_ff;
   b64q_pkg::rsp_type out_ff;
   logic              skid_valid_ff;
   b64q_pkg::rsp_type skid_ff;
   logic              accept;
   logic              out_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_62_ff <= b64q_pkg::RESET_SYMBOL_62;
         symbol_63_ff <= b64q_pkg::RESET_SYMBOL_63;
         pad_char_ff <= b64q_pkg::RESET_PAD_CHAR;
         ignore_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            b64q_pkg::CSR_SYMBOL_62: symbol_62_ff <= csr_wdata;
            b64q_pkg::CSR_SYMBOL_63: symbol_63_ff <= csr_wdata;
            b64q_pkg::CSR_PAD_CHAR: pad_char_ff <= csr_wdata;
            b64q_pkg::CSR_IGNORE_INVALID: ignore_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign lane_char[0] = req_data.char_a;
   assign lane_char[1] = req_data.char_b;
   assign lane_char[2] = req_data.char_c;
   assign lane_char[3] = req_data.char_d;

   for (genvar g = 0; g < b64q_pkg::LANES; g++) begin : g_lane
      b64q_lane u_lane (
         .char_in   (lane_char[g]),
         .symbol_62 (symbol_62_ff),
         .symbol_63 (symbol_63_ff),
         .pad_char  (pad_char_ff),
         .lane_out  (lane_res[g])
      );
   end

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   b64q_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .ignore_invalid (ignore_ff),
      .last_quartet   (req_data.last_quartet),
      .lane_a         (lane_res[0]),
      .lane_b         (lane_res[1]),
      .lane_c         (lane_res[2]),
      .lane_d         (lane_res[3]),
      .result         (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
            out_ff <= merged;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
         skid_ff <= merged;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result ahead of the output register");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && accept) |=> skid_valid_ff)
      else $error("request lost while output stalled");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result changed");

endmodule
